// File: design/sfir_pkg.sv
// Shared types, constants and coefficient tables for the stereo FIR block.
// Used by sfir_lane, sfir_seq and stereo_fir_lowpass_highpass; no dependencies.
`timescale 1ns / 1ps

package sfir_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 17;
    localparam int COEF_W         = COEF_FRAC_BITS + 1;
    localparam int LOW_TAPS       = 29;
    localparam int HIGH_TAPS      = 99;
    localparam int DEPTH          = (LOW_TAPS > HIGH_TAPS) ? LOW_TAPS : HIGH_TAPS;
    localparam int PTR_W          = $clog2(DEPTH);
    localparam int FILL_W         = $clog2(DEPTH + 1);
    localparam int TAP_W          = $clog2(HIGH_TAPS);
    localparam int LP_IDX_W       = $clog2(LOW_TAPS);
    localparam int PROD_W         = SAMPLE_BITS + COEF_W;
    localparam int ACC_W          = PROD_W + $clog2(DEPTH);

    // Configuration register map.
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam logic REG_MODE = 1'b0;

    // Filter mode codes.
    localparam logic [1:0] MODE_BYPASS     = 2'd0;
    localparam logic [1:0] MODE_LOWPASS    = 2'd1;
    localparam logic [1:0] MODE_HIGHPASS   = 2'd2;
    localparam logic [1:0] MODE_BYPASS_ALT = 2'd3;

    // Signed Q1.17 coefficients, tap 0 applies to the newest sample.
    localparam int LP_COEF [LOW_TAPS] = '{
        -1147, -1773, -2762, -3698, -4310, -4302, -3410, -1485,
        1465, 5233, 9431, 13542, 17003, 19314, 20125,
        19314, 17003, 13542, 9431, 5233, 1465,
        -1485, -3410, -4302, -4310, -3698, -2762, -1773, -1147
    };

    localparam int HP_COEF [HIGH_TAPS] = '{
        1189, 1432, 1948, 2264, 2243, 1814, 1007, -44,
        -1122, -1981, -2422, -2347, -1804, -976, -132, 454,
        594, 245, -466, -1284, -1906, -2086, -1726, -918,
        74, 900, 1246, 946, 62, -1125, -2191, -2715,
        -2429, -1337, 256, 1819, 2755, 2605, 1236, -1061,
        -3603, -5468, -5753, -3850, 341, 6320, 13066, 19257,
        23605, 25170, 23605,
        19257, 13066, 6320, 341, -3850, -5753, -5468, -3603,
        -1061, 1236, 2605, 2755, 1819, 256, -1337, -2429,
        -2715, -2191, -1125, 62, 946, 1246, 900, 74,
        -918, -1726, -2086, -1906, -1284, -466, 245, 594,
        454, -132, -976, -1804, -2347, -2422, -1981, -1122,
        -44, 1007, 1814, 2243, 2264, 1948, 1432, 1189
    };

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_left;
        logic signed [SAMPLE_BITS-1:0] sample_right;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_left;
        logic signed [SAMPLE_BITS-1:0] out_right;
    } out_item_t;

    // Per-cycle commands from the sequencer to both lanes.
    typedef struct packed {
        logic                     wr_en;
        logic [PTR_W-1:0]         wr_addr;
        logic                     rd_en;
        logic [PTR_W-1:0]         rd_addr;
        logic                     tap_ok;
        logic signed [COEF_W-1:0] coef;
        logic                     acc_clr;
    } lane_ctl_t;

    typedef struct packed {
        logic idle;
        logic load;
        logic bypass;
    } seq_stat_t;

endpackage

// File: design/sfir_lane.sv
// One channel of the stereo FIR: circular delay memory, multiply-accumulate
// pipeline and round/saturate of the sum. Depends on sfir_pkg.
`timescale 1ns / 1ps

module sfir_lane (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  sfir_pkg::lane_ctl_t                   ctl,
    input  logic signed [sfir_pkg::SAMPLE_BITS-1:0] din,
    output logic signed [sfir_pkg::SAMPLE_BITS-1:0] result
);

    localparam int FRAC = sfir_pkg::COEF_FRAC_BITS;
    localparam int SB   = sfir_pkg::SAMPLE_BITS;
    localparam int AW   = sfir_pkg::ACC_W;
    localparam int Q_W  = AW - FRAC;
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [Q_W-1:0] Q_MIN = -Q_MAX - Q_W'(1);

    logic signed [SB-1:0]                     mem [sfir_pkg::DEPTH];
    logic signed [SB-1:0]                     rdata_reg;
    logic signed [sfir_pkg::COEF_W-1:0]       coef1_reg;
    logic                                     vld1_reg;
    logic                                     ok1_reg;
    logic signed [sfir_pkg::PROD_W-1:0]       prod_reg;
    logic signed [sfir_pkg::PROD_W-1:0]       prod_next;
    logic                                     vld2_reg;
    logic signed [AW-1:0]                     acc_reg;
    logic signed [AW-1:0]                     biased;
    logic signed [Q_W-1:0]                    q;

    // Delay memory: one write port for the new sample, one registered read port.
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[ctl.wr_addr] <= din;
        end
        if (ctl.rd_en) begin
            rdata_reg <= mem[ctl.rd_addr];
        end
        coef1_reg <= ctl.coef;
        ok1_reg   <= ctl.tap_ok;
        prod_reg  <= prod_next;
    end

    // Taps that are older than anything written since reset read as zero.
    always_comb begin
        if (ok1_reg) begin
            prod_next = rdata_reg * coef1_reg;
        end else begin
            prod_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            acc_reg  <= '0;
        end else begin
            vld1_reg <= ctl.rd_en;
            vld2_reg <= vld1_reg;
            if (ctl.acc_clr) begin
                acc_reg <= '0;
            end else if (vld2_reg) begin
                acc_reg <= acc_reg + AW'(prod_reg);
            end
        end
    end

    // Adding 2^FRAC - 1 to a negative sum makes the arithmetic shift round toward zero.
    assign biased = acc_reg + {{(AW - FRAC){1'b0}}, {FRAC{acc_reg[AW-1]}}};
    assign q      = biased[AW-1:FRAC];

    always_comb begin
        if (q > Q_MAX) begin
            result = Q_MAX[SB-1:0];
        end else if (q < Q_MIN) begin
            result = Q_MIN[SB-1:0];
        end else begin
            result = q[SB-1:0];
        end
    end

endmodule

// File: design/sfir_seq.sv
// Tap sequencer shared by both lanes: delay pointers, fill count, tap counter
// and coefficient lookup. Depends on sfir_pkg.
`timescale 1ns / 1ps

module sfir_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [1:0]            mode,
    input  logic                  out_free,
    output sfir_pkg::lane_ctl_t   ctl,
    output sfir_pkg::seq_stat_t   stat
);

    localparam int PW = sfir_pkg::PTR_W;
    localparam int FW = sfir_pkg::FILL_W;
    localparam int TW = sfir_pkg::TAP_W;
    localparam int DRAIN_CYCLES = 2;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [PW-1:0] PTR_LAST = PW'(sfir_pkg::DEPTH - 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(sfir_pkg::DEPTH);
    localparam logic [TW-1:0] LOW_LAST = TW'(sfir_pkg::LOW_TAPS - 1);
    localparam logic [TW-1:0] HIGH_LAST = TW'(sfir_pkg::HIGH_TAPS - 1);

    logic [1:0]    state_reg, state_next;
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [TW-1:0] tap_reg, tap_next;
    logic          drain_reg, drain_next;
    logic          low_reg, low_next;
    logic          bypass_reg, bypass_next;
    logic [TW-1:0] tap_last;

    assign tap_last = low_reg ? LOW_LAST : HIGH_LAST;

    always_comb begin
        state_next  = state_reg;
        wptr_next   = wptr_reg;
        rptr_next   = rptr_reg;
        fill_next   = fill_reg;
        tap_next    = tap_reg;
        drain_next  = drain_reg;
        low_next    = low_reg;
        bypass_next = bypass_reg;

        ctl.wr_en   = 1'b0;
        ctl.wr_addr = wptr_reg;
        ctl.rd_en   = 1'b0;
        ctl.rd_addr = rptr_reg;
        ctl.tap_ok  = (FW'(tap_reg) < fill_reg);
        ctl.acc_clr = 1'b0;
        if (low_reg) begin
            ctl.coef = sfir_pkg::COEF_W'(sfir_pkg::LP_COEF[tap_reg[sfir_pkg::LP_IDX_W-1:0]]);
        end else begin
            ctl.coef = sfir_pkg::COEF_W'(sfir_pkg::HP_COEF[tap_reg]);
        end

        stat.idle   = (state_reg == ST_IDLE);
        stat.load   = 1'b0;
        stat.bypass = bypass_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    // The new sample goes to the write slot, which becomes tap zero.
                    ctl.wr_en   = 1'b1;
                    ctl.acc_clr = 1'b1;
                    rptr_next   = wptr_reg;
                    wptr_next   = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + PW'(1);
                    fill_next   = (fill_reg == FILL_MAX) ? fill_reg : fill_reg + FW'(1);
                    tap_next    = '0;
                    unique case (mode) inside
                        sfir_pkg::MODE_LOWPASS: begin
                            low_next    = 1'b1;
                            bypass_next = 1'b0;
                            state_next  = ST_RUN;
                        end
                        sfir_pkg::MODE_HIGHPASS: begin
                            low_next    = 1'b0;
                            bypass_next = 1'b0;
                            state_next  = ST_RUN;
                        end
                        sfir_pkg::MODE_BYPASS, sfir_pkg::MODE_BYPASS_ALT: begin
                            low_next    = 1'b0;
                            bypass_next = 1'b1;
                            state_next  = ST_DONE;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                ctl.rd_en = 1'b1;
                rptr_next = (rptr_reg == '0) ? PTR_LAST : rptr_reg - PW'(1);
                // The tap counter stops on the last tap so the table index stays in range.
                if (tap_reg == tap_last) begin
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end else begin
                    tap_next = tap_reg + TW'(1);
                end
            end
            ST_DRAIN: begin
                // Waits out the product and accumulate stages of the lanes.
                drain_next = 1'b1;
                if (drain_reg == 1'(DRAIN_CYCLES - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    stat.load  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            wptr_reg   <= '0;
            rptr_reg   <= '0;
            fill_reg   <= '0;
            tap_reg    <= '0;
            drain_reg  <= 1'b0;
            low_reg    <= 1'b0;
            bypass_reg <= 1'b1;
        end else begin
            state_reg  <= state_next;
            wptr_reg   <= wptr_next;
            rptr_reg   <= rptr_next;
            fill_reg   <= fill_next;
            tap_reg    <= tap_next;
            drain_reg  <= drain_next;
            low_reg    <= low_next;
            bypass_reg <= bypass_next;
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg <= FILL_MAX) && (wptr_reg <= PTR_LAST) && (rptr_reg <= PTR_LAST))
        else $error("delay pointer or fill count out of range");

    a_lowpass_taps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && low_reg) |-> (tap_reg <= LOW_LAST))
        else $error("low-pass tap counter ran past its table");

endmodule

// File: design/stereo_fir_lowpass_highpass.sv
// Stereo FIR filter top level: APB mode register, input word capture, two
// filter lanes under one sequencer, and the output register that merges them.
// Each lane performs one multiply-accumulate per tap. A word is taken only while the
// sequencer is idle, and it is processed and loaded into the output register before the
// next word is accepted; a full output register holds the sequencer back. Synchronous
// active-low reset clears the mode and the fill count, so the delay lines read as empty.
`timescale 1ns / 1ps

module stereo_fir_lowpass_highpass (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  sfir_pkg::in_item_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output sfir_pkg::out_item_t            m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfir_pkg::ADDR_W-1:0]    paddr,
    input  logic [sfir_pkg::DATA_W-1:0]    pwdata,
    output logic [sfir_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);

    logic [1:0]                                mode_reg;
    sfir_pkg::in_item_t                        in_reg;
    logic                                      m_valid_reg;
    sfir_pkg::out_item_t                       m_data_reg;
    logic                                      start;
    logic                                      out_free;
    sfir_pkg::lane_ctl_t                       ctl;
    sfir_pkg::seq_stat_t                       stat;
    logic signed [sfir_pkg::SAMPLE_BITS-1:0]   res_left;
    logic signed [sfir_pkg::SAMPLE_BITS-1:0]   res_right;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == sfir_pkg::REG_MODE) ? {30'd0, mode_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= sfir_pkg::MODE_BYPASS;
        end else if (psel && penable && pwrite && pready && paddr[2] == sfir_pkg::REG_MODE) begin
            mode_reg <= pwdata[1:0];
        end
    end

    assign s_ready  = stat.idle;
    assign start    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (start) begin
            in_reg <= s_data;
        end
    end

    sfir_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .mode     (mode_reg),
        .out_free (out_free),
        .ctl      (ctl),
        .stat     (stat)
    );

    sfir_lane u_lane_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .din     (s_data.sample_left),
        .result  (res_left)
    );

    sfir_lane u_lane_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .din     (s_data.sample_right),
        .result  (res_right)
    );

    // Output register: takes the input word in bypass, else both lane results.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (stat.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stat.load) begin
            if (stat.bypass) begin
                m_data_reg.out_left  <= in_reg.sample_left;
                m_data_reg.out_right <= in_reg.sample_right;
            end else begin
                m_data_reg.out_left  <= res_left;
                m_data_reg.out_right <= res_right;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !s_ready)
        else $error("a second word was taken while one is in flight");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.load |-> out_free)
        else $error("result loaded over a word not yet taken");

    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.load |=> s_ready)
        else $error("sequencer did not return to idle after delivering a result");

endmodule
